>>> hw/rtl/bvcp_pkg.sv
package bvcp_pkg;

  // Voltage/charge table, ascending in voltage.
  localparam int ROM_POINTS = 12;
  localparam int ROM_IDX_W  = $clog2(ROM_POINTS);

  localparam int MV_W   = 16;  // battery voltage in mV
  localparam int PCT_W  = 7;   // table percentages, 0..100
  localparam int SEG_W  = 8;   // segment span, offset and quotient
  localparam int NUM_W  = 16;  // scaled numerator
  localparam int RES_W  = 9;   // result, 0..100 or the not-ready marker

  localparam int TABLE_ENTRIES_DEF = 12;
  localparam int FIFO_DEPTH_DEF    = 4;

  // One quotient bit is resolved per divider stage.
  localparam int DIV_STEPS = SEG_W;

  // Rounding bias added before the division, and the reciprocal that
  // replaces the final divide by ten (exact for quotients below 1029).
  localparam logic [NUM_W-1:0] ROUND_BIAS  = 16'd5;
  localparam logic [NUM_W-1:0] DIV10_MUL   = 16'd205;
  localparam int               DIV10_SHIFT = 11;

  localparam logic [RES_W-1:0] RES_NOT_READY = 9'd256;
  localparam logic [RES_W-1:0] RES_EMPTY     = 9'd0;
  localparam logic [RES_W-1:0] RES_FULL      = 9'd100;

  localparam logic [MV_W-1:0] ROM_MV [ROM_POINTS] = '{
    16'd3100, 16'd3300, 16'd3400, 16'd3550, 16'd3650, 16'd3750,
    16'd3800, 16'd3850, 16'd3900, 16'd3950, 16'd4000, 16'd4090
  };

  localparam logic [PCT_W-1:0] ROM_PCT [ROM_POINTS] = '{
    7'd0,  7'd5,  7'd10, 7'd20, 7'd30, 7'd40,
    7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
  };

  typedef enum logic [1:0] {
    CLS_NOT_READY = 2'd0,
    CLS_EMPTY     = 2'd1,
    CLS_FULL      = 2'd2,
    CLS_INTERP    = 2'd3
  } cls_e;

  // Classified sample as it travels from the front end to the datapath.
  typedef struct packed {
    cls_e                 cls;
    logic [ROM_IDX_W-1:0] seg;   // upper point of the segment
    logic [SEG_W-1:0]     diff;  // voltage above the lower point
  } item_t;

  function automatic logic [ROM_IDX_W-1:0] seg_prev(logic [ROM_IDX_W-1:0] seg);
    return (seg == '0) ? '0 : seg - ROM_IDX_W'(1);
  endfunction

  // Voltage span of a segment.
  function automatic logic [SEG_W-1:0] seg_dm(logic [ROM_IDX_W-1:0] seg);
    logic [MV_W-1:0] d;
    d = ROM_MV[seg] - ROM_MV[seg_prev(seg)];
    return d[SEG_W-1:0];
  endfunction

  // Percentage span of a segment, times ten.
  function automatic logic [SEG_W-1:0] seg_dp10(logic [ROM_IDX_W-1:0] seg);
    logic [NUM_W-1:0] d;
    logic [NUM_W-1:0] p;
    d = NUM_W'(ROM_PCT[seg]) - NUM_W'(ROM_PCT[seg_prev(seg)]);
    p = d * NUM_W'(10);
    return p[SEG_W-1:0];
  endfunction

  // Percentage at the lower point of a segment.
  function automatic logic [PCT_W-1:0] seg_p0(logic [ROM_IDX_W-1:0] seg);
    return ROM_PCT[seg_prev(seg)];
  endfunction

endpackage

>>> hw/rtl/bvcp_front.sv
module bvcp_front #(
  parameter int TABLE_ENTRIES = bvcp_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [bvcp_pkg::MV_W-1:0]  battery_mv_i,
  input  logic                       adc_ready_i,
  output logic                       item_valid_o,
  output bvcp_pkg::item_t            item_o,
  input  logic                       item_ready_i
);
  import bvcp_pkg::*;

  localparam int NPTS = (TABLE_ENTRIES > ROM_POINTS) ? ROM_POINTS :
                        ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);

  logic [NPTS-1:0]      ge;
  logic [ROM_IDX_W-1:0] seg;
  logic [MV_W-1:0]      m0;
  logic [MV_W-1:0]      diff_full;
  item_t                item_d;
  item_t                item_q;
  logic                 valid_q;
  logic                 load;

  // One comparator per table point.
  always_comb begin
    for (int k = 0; k < NPTS; k++) begin
      ge[k] = (battery_mv_i >= ROM_MV[k]);
    end
  end

  // The segment is closed by the first point above the voltage.
  always_comb begin
    seg = ROM_IDX_W'(1);
    m0  = ROM_MV[0];
    for (int k = NPTS - 1; k >= 1; k--) begin
      if (!ge[k]) begin
        seg = ROM_IDX_W'(k);
        m0  = ROM_MV[k-1];
      end
    end
    diff_full = battery_mv_i - m0;

    item_d.seg  = seg;
    item_d.diff = diff_full[SEG_W-1:0];
    if (!adc_ready_i) begin
      item_d.cls = CLS_NOT_READY;
    end else if (battery_mv_i <= ROM_MV[0]) begin
      item_d.cls = CLS_EMPTY;
    end else if (ge[NPTS-1]) begin
      item_d.cls = CLS_FULL;
    end else begin
      item_d.cls = CLS_INTERP;
    end
  end

  assign load         = !valid_q || item_ready_i;
  assign in_stall_o   = !load;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= item_d;
    end
  end

  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !item_ready_i |=> valid_q && $stable(item_q))
    else $error("front register changed while the queue was full");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> valid_q)
    else $error("accepted transaction was not captured");

endmodule

>>> hw/rtl/bvcp_fifo.sv
module bvcp_fifo #(
  parameter int DEPTH = bvcp_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  input  bvcp_pkg::item_t wr_item_i,
  output logic            wr_ready_o,
  output logic            rd_valid_o,
  output bvcp_pkg::item_t rd_item_o,
  input  logic            rd_ready_i
);
  import bvcp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          wr_en;
  logic          rd_en;

  assign wr_ready_o = (cnt_q != CW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count beyond its depth");

  a_count_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && !rd_en |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("queue count missed a push");

endmodule

>>> hw/rtl/bvcp_back.sv
module bvcp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  bvcp_pkg::item_t            item_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bvcp_pkg::RES_W-1:0] charge_percent_o
);
  import bvcp_pkg::*;

  // Stage 0 forms the numerator, the following stages each resolve one
  // quotient bit of a restoring division.
  localparam int NST = DIV_STEPS + 1;

  typedef struct packed {
    cls_e                 cls;
    logic [ROM_IDX_W-1:0] seg;
    logic [SEG_W-1:0]     dm;
    logic [SEG_W-1:0]     rem;
    logic [SEG_W-1:0]     dvd;
    logic [SEG_W-1:0]     quo;
  } div_t;

  function automatic div_t div_step(div_t s);
    div_t            n;
    logic [SEG_W:0]  r;
    logic [SEG_W:0]  diff;
    logic            take;
    n    = s;
    r    = {s.rem, s.dvd[SEG_W-1]};
    take = (r >= {1'b0, s.dm});
    diff = r - {1'b0, s.dm};
    n.rem = take ? diff[SEG_W-1:0] : r[SEG_W-1:0];
    n.dvd = {s.dvd[SEG_W-2:0], 1'b0};
    n.quo = {s.quo[SEG_W-2:0], take};
    return n;
  endfunction

  div_t             st_q [NST];
  div_t             st_d [NST];
  logic [NST-1:0]   vld_q;
  logic [NST:0]     en;
  logic [NUM_W-1:0] prod;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] q10_full;
  logic [RES_W-1:0] interp;
  logic [RES_W-1:0] res_d;
  logic [RES_W-1:0] res_q;
  logic             out_vld_q;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    en[NST] = !out_vld_q || !out_stall_i;
    for (int i = NST - 1; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    prod = NUM_W'(seg_dp10(item_i.seg)) * NUM_W'(item_i.diff);
    num  = prod + ROUND_BIAS;

    st_d[0].cls = item_i.cls;
    st_d[0].seg = item_i.seg;
    st_d[0].dm  = seg_dm(item_i.seg);
    st_d[0].rem = num[NUM_W-1:SEG_W];
    st_d[0].dvd = num[SEG_W-1:0];
    st_d[0].quo = '0;
    for (int i = 1; i < NST; i++) begin
      st_d[i] = div_step(st_q[i-1]);
    end
  end

  always_comb begin
    q10_full = (NUM_W'(st_q[NST-1].quo) * DIV10_MUL) >> DIV10_SHIFT;
    interp   = RES_W'(seg_p0(st_q[NST-1].seg)) + q10_full[RES_W-1:0];
    case (st_q[NST-1].cls)
      CLS_NOT_READY: res_d = RES_NOT_READY;
      CLS_EMPTY:     res_d = RES_EMPTY;
      CLS_FULL:      res_d = RES_FULL;
      CLS_INTERP:    res_d = interp;
      default:       res_d = RES_NOT_READY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
      if (en[NST]) begin
        out_vld_q <= vld_q[NST-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NST; i++) begin
      if (en[i]) begin
        st_q[i] <= st_d[i];
      end
    end
    if (en[NST]) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign charge_percent_o = res_q;

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q != RES_NOT_READY |-> res_q <= RES_FULL)
    else $error("charge result beyond full scale");

  a_last_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NST-1] && en[NST] |=> out_vld_q)
    else $error("finished division lost on its way to the output");

  a_backpressure_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en[0] |-> (&vld_q) && out_vld_q)
    else $error("datapath refused work while a stage was empty");

endmodule

>>> hw/rtl/battery_voltage_to_charge_percent_top.sv
// Battery voltage to state-of-charge converter.
//
// The input channel carries one transaction per voltage sample:
// battery_mv_i in millivolts and adc_ready_i, under in_valid_i/in_stall_o.
// Each transaction yields exactly one charge_percent_o on the output
// channel (out_valid_o/out_stall_i): 0 to 100 percent, or 256 when the
// ADC reading was flagged as not ready. Between table points the charge
// is linearly interpolated and truncated.
//
// A front end classifies the sample against the table, registers it and
// writes it into a small queue. The datapath behind the queue forms the
// scaled numerator, runs a restoring divider of one quotient bit per
// stage, and registers the result. From acceptance to out_valid_o the
// sample passes the front register, the queue, the numerator stage,
// eight divider stages and the output register. Throughput is one
// transaction per cycle while the receiver does not stall.
//
// When out_stall_i is high, the output holds its result and the divider
// stages fill up; the queue then absorbs up to FIFO_DEPTH more samples
// before in_stall_o rises. Reset empties every stage and the queue.
module battery_voltage_to_charge_percent_top #(
  parameter int TABLE_ENTRIES = bvcp_pkg::TABLE_ENTRIES_DEF,
  parameter int FIFO_DEPTH    = bvcp_pkg::FIFO_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [bvcp_pkg::MV_W-1:0]  battery_mv_i,
  input  logic                       adc_ready_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bvcp_pkg::RES_W-1:0] charge_percent_o
);
  import bvcp_pkg::*;

  // Front end to queue.
  logic  fq_valid;
  logic  fq_ready;
  item_t fq_item;

  // Queue to datapath.
  logic  qb_valid;
  logic  qb_ready;
  item_t qb_item;

  bvcp_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .battery_mv_i(battery_mv_i),
    .adc_ready_i (adc_ready_i),
    .item_valid_o(fq_valid),
    .item_o      (fq_item),
    .item_ready_i(fq_ready)
  );

  // The queue lets the front end keep taking samples while the output
  // side is stalled.
  bvcp_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fq_valid),
    .wr_item_i (fq_item),
    .wr_ready_o(fq_ready),
    .rd_valid_o(qb_valid),
    .rd_item_o (qb_item),
    .rd_ready_i(qb_ready)
  );

  bvcp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (qb_valid),
    .item_i          (qb_item),
    .in_ready_o      (qb_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .charge_percent_o(charge_percent_o)
  );

endmodule
